FILE: rtl/ulex_pkg.sv
// Shared types, constants and helper functions of the UTF-8 expression lexer.
// Used by every module of the lexer; depends on nothing else.

package ulex_pkg;

  // Width of the byte position counter and of the token fields.
  localparam int unsigned POS_W      = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned VAL_W      = 63;
  localparam int unsigned CP_W       = 21;

  // Result queue: a full item may add this many tokens at once.
  localparam int unsigned MAX_TOKENS = 3;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned CNT_W      = $clog2(QDEPTH + 1);

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam int unsigned OUT_TUSER_W = 4;

  // Largest number value and the bound above which a times-ten step overflows.
  localparam logic [VAL_W-1:0] MAX63       = '1;
  localparam logic [63:0]      MAX63_WIDE  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]      MAX63_DIV10 = MAX63_WIDE / 64'd10;

  // Characters with a meaning of their own.
  localparam logic [CP_W-1:0] CH_NUL   = 21'h00;
  localparam logic [CP_W-1:0] CH_ZERO  = 21'h30;
  localparam logic [CP_W-1:0] CH_NINE  = 21'h39;
  localparam logic [CP_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CP_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CP_W-1:0] CH_STAR  = 21'h2A;
  localparam logic [CP_W-1:0] CH_SLASH = 21'h2F;
  localparam logic [CP_W-1:0] CH_OPEN  = 21'h28;
  localparam logic [CP_W-1:0] CH_CLOSE = 21'h29;

  typedef enum logic [3:0] {
    TK_EOF    = 4'd0,
    TK_BAD    = 4'd1,
    TK_SPACE  = 4'd2,
    TK_NUMBER = 4'd3,
    TK_PLUS   = 4'd4,
    TK_MINUS  = 4'd5,
    TK_STAR   = 4'd6,
    TK_SLASH  = 4'd7,
    TK_OPEN   = 4'd8,
    TK_CLOSE  = 4'd9
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LARGE   = 2'd1,
    ERR_BADCHAR = 2'd2,
    ERR_UTF8    = 2'd3
  } error_e;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_SPACE  = 2'd1,
    RUN_NUMBER = 2'd2
  } run_kind_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic                  end_of_text;
    logic [IN_TDATA_W-1:0] in_byte;
  } in_item_t;

  // One result token.
  typedef struct packed {
    token_kind_e      kind;
    logic [LEN_W-1:0] start_pos;
    logic [LEN_W-1:0] byte_length;
    logic [VAL_W-1:0] number_value;
    error_e           error_code;
    logic             last;
  } token_t;

  typedef token_t [MAX_TOKENS-1:0] tok_vec_t;

  // Tokens produced by one item, handed to the result queue.
  typedef struct packed {
    logic [1:0] n;
    tok_vec_t   tok;
  } push_t;

  // Low 32 bits of a position.
  function automatic logic [LEN_W-1:0] pos_lo(input logic [POS_W-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[LEN_W-1:0];
  endfunction

  // Position difference saturated to the length field.
  function automatic logic [LEN_W-1:0] len_sat(input logic [POS_W-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return w[LEN_W-1:0];
  endfunction

  // Unicode space separators and the line and paragraph separators.
  function automatic logic is_space(input logic [CP_W-1:0] c);
    return c == 21'h20 || c == 21'hA0 || c == 21'h1680 ||
           (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028 ||
           c == 21'h2029 || c == 21'h202F || c == 21'h205F || c == 21'h3000;
  endfunction

  // Operator kind of a code point; TK_EOF means it is no operator.
  function automatic token_kind_e op_kind(input logic [CP_W-1:0] c);
    token_kind_e k;
    unique case (c)
      CH_PLUS:  k = TK_PLUS;
      CH_MINUS: k = TK_MINUS;
      CH_STAR:  k = TK_STAR;
      CH_SLASH: k = TK_SLASH;
      CH_OPEN:  k = TK_OPEN;
      CH_CLOSE: k = TK_CLOSE;
      default:  k = TK_EOF;
    endcase
    return k;
  endfunction

  // Encoded length of a code point in bytes.
  function automatic logic [LEN_W-1:0] cp_len(input logic [CP_W-1:0] c);
    logic [LEN_W-1:0] l;
    if (c < 21'h80) begin
      l = 32'd1;
    end else if (c < 21'h800) begin
      l = 32'd2;
    end else if (c < 21'h10000) begin
      l = 32'd3;
    end else begin
      l = 32'd4;
    end
    return l;
  endfunction

  function automatic token_t make_tok(input token_kind_e kind,
                                      input logic [POS_W-1:0] start,
                                      input logic [LEN_W-1:0] len,
                                      input logic [VAL_W-1:0] value,
                                      input error_e err);
    token_t t;
    t.kind         = kind;
    t.start_pos    = pos_lo(start);
    t.byte_length  = len;
    t.number_value = value;
    t.error_code   = err;
    t.last         = 1'b0;
    return t;
  endfunction

  // Token that closes the open run; only called while a run is open.
  function automatic token_t run_token(input run_kind_e rk,
                                       input logic [POS_W-1:0] rs,
                                       input logic [POS_W-1:0] end_pos,
                                       input logic [VAL_W-1:0] acc,
                                       input logic tl);
    token_t t;
    if (rk == RUN_NUMBER) begin
      t = make_tok(TK_NUMBER, rs, len_sat(end_pos - rs), tl ? '0 : acc,
                   tl ? ERR_LARGE : ERR_NONE);
    end else begin
      t = make_tok(TK_SPACE, rs, len_sat(end_pos - rs), '0, ERR_NONE);
    end
    return t;
  endfunction

endpackage

FILE: rtl/ulex_in_reg.sv
// Input register of the lexer: holds one accepted word until the step logic takes it.
// Depends on ulex_pkg.

module ulex_in_reg
  import ulex_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  input  logic                  s_last_i,
  output logic                  item_valid_o,
  output in_item_t              item_o,
  input  logic                  take_i
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // A new word may enter when the register is empty or is being emptied.
  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q.in_byte     <= s_data_i;
      item_q.end_of_text <= s_last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/ulex_step.sv
// Decode and tokenize step: UTF-8 decoding, run tracking and token building for one word.
// Holds the lexer state registers. Depends on ulex_pkg.

module ulex_step
  import ulex_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  input  logic     room_i,
  output logic     take_o,
  output push_t    push_o
);

  // Lexer state.
  run_kind_e        run_kind_q, run_kind_d;
  logic [POS_W-1:0] run_start_q, run_start_d;
  logic [POS_W-1:0] byte_pos_q, byte_pos_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             too_large_q, too_large_d;
  logic [CP_W-1:0]  cp_q, cp_d;
  logic [1:0]       left_q, left_d;
  logic [POS_W-1:0] seq_start_q, seq_start_d;

  // Working values.
  tok_vec_t         tok_d;
  logic [1:0]       n_d;
  logic [7:0]       b;
  logic             second, cont, lead, fin;
  logic [CP_W-1:0]  fc;
  logic [POS_W-1:0] fs;
  token_kind_e      op;
  logic [63:0]      prod;

  assign take_o = item_valid_i && room_i;
  assign b      = item_i.in_byte;

  // Whether the byte can continue the pending sequence.
  always_comb begin
    second = (byte_pos_q - seq_start_q) == POS_W'(1);
    cont   = b[7:6] == 2'b10;
    if (second && left_q == 2'd2) begin
      if (cp_q == 21'h00 && b < 8'hA0) cont = 1'b0;
      if (cp_q == 21'h0D && b > 8'h9F) cont = 1'b0;
    end
    if (second && left_q == 2'd3) begin
      if (cp_q == 21'h00 && b < 8'h90) cont = 1'b0;
      if (cp_q == 21'h04 && b > 8'h8F) cont = 1'b0;
    end
  end

  // Next state and tokens. At most one open run is closed per word, and it
  // is always the first token.
  always_comb begin
    run_kind_d  = run_kind_q;
    run_start_d = run_start_q;
    byte_pos_d  = byte_pos_q;
    acc_d       = acc_q;
    too_large_d = too_large_q;
    cp_d        = cp_q;
    left_d      = left_q;
    seq_start_d = seq_start_q;
    tok_d       = '0;
    n_d         = 2'd0;
    lead        = 1'b1;
    fin         = 1'b0;
    fc          = '0;
    fs          = '0;
    op          = TK_EOF;
    prod        = '0;

    if (item_i.end_of_text) begin
      // End of text: close the run, report a cut-off sequence, end of file.
      if (left_d != 2'd0) begin
        if (run_kind_d != RUN_NONE) begin
          tok_d[n_d] = run_token(run_kind_d, run_start_d, seq_start_d, acc_d, too_large_d);
          n_d        = n_d + 2'd1;
        end
        run_kind_d = RUN_NONE;
        tok_d[n_d] = make_tok(TK_BAD, seq_start_d, len_sat(byte_pos_d - seq_start_d),
                              '0, ERR_UTF8);
        n_d        = n_d + 2'd1;
        left_d     = 2'd0;
      end else begin
        if (run_kind_d != RUN_NONE) begin
          tok_d[n_d] = run_token(run_kind_d, run_start_d, byte_pos_d, acc_d, too_large_d);
          n_d        = n_d + 2'd1;
        end
        run_kind_d = RUN_NONE;
      end
      tok_d[n_d] = make_tok(TK_EOF, byte_pos_d, '0, '0, ERR_NONE);
      n_d        = n_d + 2'd1;
    end else begin
      // Pending multi-byte sequence.
      if (left_d != 2'd0) begin
        if (cont) begin
          cp_d       = {cp_q[CP_W-7:0], b[5:0]};
          left_d     = left_d - 2'd1;
          byte_pos_d = byte_pos_d + POS_W'(1);
          lead       = 1'b0;
          if (left_d == 2'd0) begin
            fin = 1'b1;
            fc  = cp_d;
            fs  = seq_start_d;
          end
        end else begin
          // Broken sequence: report it, then take the byte as a lead byte.
          if (run_kind_d != RUN_NONE) begin
            tok_d[n_d] = run_token(run_kind_d, run_start_d, seq_start_d, acc_d,
                                   too_large_d);
            n_d        = n_d + 2'd1;
          end
          run_kind_d = RUN_NONE;
          tok_d[n_d] = make_tok(TK_BAD, seq_start_d, len_sat(byte_pos_d - seq_start_d),
                                '0, ERR_UTF8);
          n_d        = n_d + 2'd1;
          left_d     = 2'd0;
        end
      end

      // Lead byte.
      if (lead) begin
        if (b < 8'h80) begin
          fin        = 1'b1;
          fc         = CP_W'(b);
          fs         = byte_pos_d;
          byte_pos_d = byte_pos_d + POS_W'(1);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          cp_d        = CP_W'(b[4:0]);
          left_d      = 2'd1;
          seq_start_d = byte_pos_d;
          byte_pos_d  = byte_pos_d + POS_W'(1);
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          cp_d        = CP_W'(b[3:0]);
          left_d      = 2'd2;
          seq_start_d = byte_pos_d;
          byte_pos_d  = byte_pos_d + POS_W'(1);
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          cp_d        = CP_W'(b[2:0]);
          left_d      = 2'd3;
          seq_start_d = byte_pos_d;
          byte_pos_d  = byte_pos_d + POS_W'(1);
        end else begin
          // Byte that can never start a sequence.
          if (run_kind_d != RUN_NONE) begin
            tok_d[n_d] = run_token(run_kind_d, run_start_d, byte_pos_d, acc_d,
                                   too_large_d);
            n_d        = n_d + 2'd1;
          end
          run_kind_d = RUN_NONE;
          tok_d[n_d] = make_tok(TK_BAD, byte_pos_d, 32'd1, '0, ERR_UTF8);
          n_d        = n_d + 2'd1;
          byte_pos_d = byte_pos_d + POS_W'(1);
        end
      end

      // Complete code point: classify it.
      if (fin) begin
        op = op_kind(fc);
        if (is_space(fc)) begin
          if (run_kind_d != RUN_SPACE) begin
            if (run_kind_d != RUN_NONE) begin
              tok_d[n_d] = run_token(run_kind_d, run_start_d, fs, acc_d, too_large_d);
              n_d        = n_d + 2'd1;
            end
            run_kind_d  = RUN_SPACE;
            run_start_d = fs;
          end
        end else if (fc >= CH_ZERO && fc <= CH_NINE) begin
          if (run_kind_d != RUN_NUMBER) begin
            if (run_kind_d != RUN_NONE) begin
              tok_d[n_d] = run_token(run_kind_d, run_start_d, fs, acc_d, too_large_d);
              n_d        = n_d + 2'd1;
            end
            run_kind_d  = RUN_NUMBER;
            run_start_d = fs;
            acc_d       = '0;
            too_large_d = 1'b0;
          end
          // Value times ten plus the digit, as shifts and adds.
          prod = ({1'b0, acc_d} << 3) + ({1'b0, acc_d} << 1) + 64'(fc - CH_ZERO);
          if (!too_large_d) begin
            if (64'(acc_d) > MAX63_DIV10) begin
              too_large_d = 1'b1;
            end else if (prod > MAX63_WIDE) begin
              too_large_d = 1'b1;
            end else begin
              acc_d = prod[VAL_W-1:0];
            end
          end
        end else begin
          if (run_kind_d != RUN_NONE) begin
            tok_d[n_d] = run_token(run_kind_d, run_start_d, fs, acc_d, too_large_d);
            n_d        = n_d + 2'd1;
          end
          run_kind_d = RUN_NONE;
          if (fc == CH_NUL) begin
            tok_d[n_d] = make_tok(TK_EOF, fs, '0, '0, ERR_NONE);
          end else if (op != TK_EOF) begin
            tok_d[n_d] = make_tok(op, fs, 32'd1, '0, ERR_NONE);
          end else begin
            tok_d[n_d] = make_tok(TK_BAD, fs, cp_len(fc), '0, ERR_BADCHAR);
          end
          n_d = n_d + 2'd1;
        end
      end
    end

    // Mark the final token of this word.
    if (n_d != 2'd0) begin
      tok_d[n_d - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q  <= RUN_NONE;
      run_start_q <= '0;
      byte_pos_q  <= '0;
      acc_q       <= '0;
      too_large_q <= 1'b0;
      cp_q        <= '0;
      left_q      <= 2'd0;
      seq_start_q <= '0;
    end else if (take_o) begin
      run_kind_q  <= run_kind_d;
      run_start_q <= run_start_d;
      byte_pos_q  <= byte_pos_d;
      acc_q       <= acc_d;
      too_large_q <= too_large_d;
      cp_q        <= cp_d;
      left_q      <= left_d;
      seq_start_q <= seq_start_d;
    end
  end

  assign push_o.n   = take_o ? n_d : 2'd0;
  assign push_o.tok = tok_d;

endmodule

FILE: rtl/ulex_out_queue.sv
// Lexer result queue: takes up to three tokens a cycle and sends one a cycle while
// ready. Shift-style register queue, head always in slot zero. Depends on ulex_pkg.

module ulex_out_queue
  import ulex_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   room_o,
  output logic   valid_o,
  input  logic   ready_i,
  output token_t head_o
);

  token_t [QDEPTH-1:0] q_q, q_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    base;
  logic                pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign head_o  = q_q[0];

  // Room for a whole word's worth of tokens, judged from the registered count.
  assign room_o  = count_q <= CNT_W'(QDEPTH - MAX_TOKENS);

  // Shift out the head, then place new tokens behind what remains.
  always_comb begin
    base = count_q - CNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_d[i] = q_q[i + 1];
      end else begin
        q_d[i] = q_q[i];
      end
      for (int k = 0; k < MAX_TOKENS; k++) begin
        if (2'(k) < push_i.n && base + CNT_W'(k) == CNT_W'(i)) begin
          q_d[i] = push_i.tok[k];
        end
      end
    end
    count_d = base + CNT_W'(push_i.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

FILE: rtl/utf8_expression_lexer_core.sv
// Top level of the UTF-8 expression lexer: input register, tokenize step, result queue.
// Depends on ulex_pkg, ulex_in_reg, ulex_step and ulex_out_queue.
//
// Usage: bytes of UTF-8 text enter on the slave stream, one per word, tdata[7:0]
// holding the byte; a word with tlast high marks end of text (its byte is ignored),
// closes any open run and gives an end-of-file token. Tokens leave on the master
// stream: tuser carries the kind, tdata the position, length, value and error code,
// and tlast marks the final token caused by one input word.
// An accepted word is held in the input register and is decoded from it once the
// result queue has room; its tokens are registered in the queue, whose head is offered.
// Throughput: one byte per cycle while each byte gives at most one token and the
// receiver keeps up; the four-entry result queue must have room for three tokens
// before a byte is decoded, so a byte that gives two or three tokens, or a receiver
// stall, holds the input back.
// Reset clears the position counter, the open run, the partial code point, the input register
// and the result queue. A stalled receiver keeps the head token steady; the input side keeps
// taking words until the input register holds a word the result queue has no room for.

module utf8_expression_lexer_core
  import ulex_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic                   s_axis_tlast_i,  // end_of_text
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // [31:0] start_pos, [63:32] byte_length,
                                                  // [126:64] number_value, [128:127] error_code
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,  // [3:0] token_kind
  output logic                   m_axis_tlast_o   // last
);

  logic     item_valid;
  in_item_t item;
  logic     take;
  logic     room;
  push_t    push;
  token_t   head;

  ulex_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  ulex_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .room_i       (room),
    .take_o       (take),
    .push_o       (push)
  );

  ulex_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  // Pack the head token onto the master stream.
  assign m_axis_tdata_o = {7'b0, head.error_code, head.number_value,
                           head.byte_length, head.start_pos};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

FILE: rtl/ulex_checker.sv
// Port-level checks for the UTF-8 expression lexer, bound to its top level.
// Depends on ulex_pkg and utf8_expression_lexer_core.

module ulex_checker
  import ulex_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  // A stalled token holds still.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("token changed while stalled");

  // End of file always closes the word's tokens and has no length.
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == TK_EOF |->
      m_axis_tlast_o && m_axis_tdata_o[63:32] == '0)
    else $error("end-of-file token not last or with length");

  // Only number tokens carry a value.
  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != TK_NUMBER |-> m_axis_tdata_o[126:64] == '0)
    else $error("value on a token that is no number");

  // Too-large error only on numbers, which then report zero.
  a_large: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[128:127] == ERR_LARGE |->
      m_axis_tuser_o == TK_NUMBER && m_axis_tdata_o[126:64] == '0)
    else $error("too-large error on a wrong token");

  // Bad-character and invalid UTF-8 errors only on bad tokens.
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[128:127] == ERR_BADCHAR ||
                        m_axis_tdata_o[128:127] == ERR_UTF8) |->
      m_axis_tuser_o == TK_BAD && m_axis_tdata_o[63:32] != '0)
    else $error("character error on a wrong token");

endmodule

bind utf8_expression_lexer_core ulex_checker u_ulex_checker (.*);

FILE: test/tb.sv
// Self-checking bench for utf8_expression_lexer_core: streams UTF-8 bytes in, checks the tokens.
// Depends on ulex_pkg and the lexer RTL; the expected tokens come from a lexer model kept here.

module tb;
  import ulex_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_WORDS = 250;
  localparam int unsigned LONG_HOLD    = 80;

  // One input word waiting to be sent; pause holds it back until no token is due.
  typedef struct {
    logic [7:0] b;
    logic       eot;
    logic       pause;
  } text_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;  // [7:0] in_byte
  logic                   s_axis_tlast_i = 1'b0;  // end_of_text
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;  // [31:0] start_pos, [63:32] byte_length,
                                           // [126:64] number_value, [128:127] error_code
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;  // [3:0] token_kind
  logic                   m_axis_tlast_o;

  utf8_expression_lexer_core dut (.*);

  always #2 clk_i = ~clk_i;

  text_word_t  text_words[$];
  token_t      tokens_due[$];
  logic        pause_next = 1'b0;

  // Lexer state as the model sees it.
  run_kind_e   lx_run = RUN_NONE;
  logic [31:0] lx_run_start = '0;
  logic [31:0] lx_pos = '0;
  logic [62:0] lx_acc = '0;
  logic        lx_big = 1'b0;
  logic [20:0] lx_cp = '0;
  logic [1:0]  lx_left = '0;
  logic [31:0] lx_seq_start = '0;

  int unsigned n_fail = 0;
  int unsigned words_taken = 0;
  int unsigned n_tokens = 0;
  int unsigned n_large = 0;
  int unsigned n_utf8 = 0;
  int unsigned n_eof = 0;

  // ---------------------------------------------------------------------------
  // Lexer model
  // ---------------------------------------------------------------------------

  function automatic void add_token(token_kind_e k, logic [31:0] start, logic [31:0] len,
                                    logic [62:0] value, error_e err);
    token_t t;
    t.kind         = k;
    t.start_pos    = start;
    t.byte_length  = len;
    t.number_value = value;
    t.error_code   = err;
    t.last         = 1'b0;
    tokens_due.push_back(t);
  endfunction

  // Emit the open whitespace or number run, ending at end_pos.
  function automatic void close_run(logic [31:0] end_pos);
    if (lx_run == RUN_SPACE) begin
      add_token(TK_SPACE, lx_run_start, end_pos - lx_run_start, '0, ERR_NONE);
    end else if (lx_run == RUN_NUMBER) begin
      add_token(TK_NUMBER, lx_run_start, end_pos - lx_run_start, lx_big ? '0 : lx_acc,
                lx_big ? ERR_LARGE : ERR_NONE);
    end
    lx_run = RUN_NONE;
  endfunction

  function automatic logic is_zs(logic [20:0] c);
    case (c)
      21'h20, 21'hA0, 21'h1680, 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000: begin
        return 1'b1;
      end
      default: begin
        return c >= 21'h2000 && c <= 21'h200A;
      end
    endcase
  endfunction

  // A complete code point that started at byte offset start.
  function automatic void finish_char(logic [20:0] c, logic [31:0] start);
    logic [31:0] n;
    logic [63:0] t;
    token_kind_e op;
    n = c < 21'h80 ? 32'd1 : c < 21'h800 ? 32'd2 : c < 21'h10000 ? 32'd3 : 32'd4;
    case (c)
      CH_PLUS:  op = TK_PLUS;
      CH_MINUS: op = TK_MINUS;
      CH_STAR:  op = TK_STAR;
      CH_SLASH: op = TK_SLASH;
      CH_OPEN:  op = TK_OPEN;
      CH_CLOSE: op = TK_CLOSE;
      default:  op = TK_EOF;
    endcase
    if (is_zs(c)) begin
      if (lx_run != RUN_SPACE) begin
        close_run(start);
        lx_run = RUN_SPACE;
        lx_run_start = start;
      end
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (lx_run != RUN_NUMBER) begin
        close_run(start);
        lx_run = RUN_NUMBER;
        lx_run_start = start;
        lx_acc = '0;
        lx_big = 1'b0;
      end
      // Once the value no longer fits in 63 bits the run only counts bytes.
      if (!lx_big) begin
        if ({1'b0, lx_acc} > MAX63_DIV10) begin
          lx_big = 1'b1;
        end else begin
          t = {1'b0, lx_acc} * 64'd10 + 64'(c - CH_ZERO);
          if (t > MAX63_WIDE) begin
            lx_big = 1'b1;
          end else begin
            lx_acc = t[62:0];
          end
        end
      end
      return;
    end
    close_run(start);
    if (c == CH_NUL) begin
      add_token(TK_EOF, start, 32'd0, '0, ERR_NONE);
    end else if (op != TK_EOF) begin
      add_token(op, start, 32'd1, '0, ERR_NONE);
    end else begin
      add_token(TK_BAD, start, n, '0, ERR_BADCHAR);
    end
  endfunction

  // Whether b may follow the pending partial sequence (no overlong, surrogate or > 10FFFF).
  function automatic logic continues(logic [7:0] b);
    logic second;
    second = (lx_pos - lx_seq_start) == 32'd1;
    if (b[7:6] != 2'b10) begin
      return 1'b0;
    end
    if (second && lx_left == 2'd2) begin
      if (lx_cp == 21'h0 && b < 8'hA0) return 1'b0;
      if (lx_cp == 21'hD && b > 8'h9F) return 1'b0;
    end
    if (second && lx_left == 2'd3) begin
      if (lx_cp == 21'h0 && b < 8'h90) return 1'b0;
      if (lx_cp == 21'h4 && b > 8'h8F) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [31:0] here;
    if (lx_left != 2'd0) begin
      if (continues(b)) begin
        lx_cp = {lx_cp[14:0], b[5:0]};
        lx_left = lx_left - 2'd1;
        lx_pos = lx_pos + 32'd1;
        if (lx_left == 2'd0) finish_char(lx_cp, lx_seq_start);
        return;
      end
      // The broken sequence becomes one token; b is then read as a fresh lead byte.
      close_run(lx_seq_start);
      add_token(TK_BAD, lx_seq_start, lx_pos - lx_seq_start, '0, ERR_UTF8);
      lx_left = 2'd0;
    end
    if (b < 8'h80) begin
      here = lx_pos;
      lx_pos = lx_pos + 32'd1;
      finish_char({13'd0, b}, here);
      return;
    end
    if (b >= 8'hC2 && b <= 8'hDF) begin
      lx_cp = {16'd0, b[4:0]};
      lx_left = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      lx_cp = {17'd0, b[3:0]};
      lx_left = 2'd2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      lx_cp = {18'd0, b[2:0]};
      lx_left = 2'd3;
    end else begin
      close_run(lx_pos);
      add_token(TK_BAD, lx_pos, 32'd1, '0, ERR_UTF8);
      lx_pos = lx_pos + 32'd1;
      return;
    end
    lx_seq_start = lx_pos;
    lx_pos = lx_pos + 32'd1;
  endfunction

  // Expected tokens of one accepted word, the final one marked last.
  function automatic void lex_word(logic [7:0] b, logic eot);
    int unsigned n0;
    token_t t;
    n0 = tokens_due.size();
    if (eot) begin
      if (lx_left != 2'd0) begin
        close_run(lx_seq_start);
        add_token(TK_BAD, lx_seq_start, lx_pos - lx_seq_start, '0, ERR_UTF8);
        lx_left = 2'd0;
      end else begin
        close_run(lx_pos);
      end
      add_token(TK_EOF, lx_pos, 32'd0, '0, ERR_NONE);
    end else begin
      take_byte(b);
    end
    if (tokens_due.size() > n0) begin
      t = tokens_due.pop_back();
      t.last = 1'b1;
      tokens_due.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic void put_word(logic [7:0] b, logic eot);
    text_word_t w;
    w.b = b;
    w.eot = eot;
    w.pause = pause_next;
    pause_next = 1'b0;
    text_words.push_back(w);
  endfunction

  function automatic void put_char(logic [20:0] c);
    if (c < 21'h80) begin
      put_word(c[7:0], 1'b0);
    end else if (c < 21'h800) begin
      put_word({3'b110, c[10:6]}, 1'b0);
      put_word({2'b10, c[5:0]}, 1'b0);
    end else if (c < 21'h10000) begin
      put_word({4'b1110, c[15:12]}, 1'b0);
      put_word({2'b10, c[11:6]}, 1'b0);
      put_word({2'b10, c[5:0]}, 1'b0);
    end else begin
      put_word({5'b11110, c[20:18]}, 1'b0);
      put_word({2'b10, c[17:12]}, 1'b0);
      put_word({2'b10, c[11:6]}, 1'b0);
      put_word({2'b10, c[5:0]}, 1'b0);
    end
  endfunction

  function automatic void put_string(string s);
    for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
  endfunction

  function automatic logic [20:0] any_space();
    case ($urandom_range(0, 9))
      0: return 21'hA0;
      1: return 21'h1680;
      2: return 21'h2000 + 21'($urandom_range(0, 10));
      3: return 21'h2028;
      4: return 21'h2029;
      5: return 21'h202F;
      6: return 21'h205F;
      7: return 21'h3000;
      default: return 21'h20;
    endcase
  endfunction

  // A valid code point of any encoded length, surrogates excluded.
  function automatic logic [20:0] any_char();
    logic [20:0] c;
    case ($urandom_range(0, 3))
      0: c = 21'($urandom_range(1, 'h7F));
      1: c = 21'($urandom_range('h80, 'h7FF));
      2: begin
        c = 21'($urandom_range('h800, 'hFFFF));
        if (c >= 21'hD800 && c <= 21'hDFFF) c = c - 21'h1000;
      end
      default: c = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return c;
  endfunction

  function automatic void put_random_text();
    int unsigned r;
    int unsigned n;
    logic [7:0] lead;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      // Number run, now and then long enough to overflow.
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) put_word(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    end else if (r < 40) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put_char(any_space());
    end else if (r < 58) begin
      case ($urandom_range(0, 5))
        0: put_char(CH_PLUS);
        1: put_char(CH_MINUS);
        2: put_char(CH_STAR);
        3: put_char(CH_SLASH);
        4: put_char(CH_OPEN);
        default: put_char(CH_CLOSE);
      endcase
    end else if (r < 72) begin
      put_char(any_char());
    end else if (r < 80) begin
      if ($urandom_range(0, 1) == 0) put_word(8'h00, 1'b0);
      else put_word(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 90) begin
      // Lead byte, some continuation bytes, then any byte that may break it.
      lead = 8'($urandom_range('hC2, 'hF4));
      put_word(lead, 1'b0);
      n = lead >= 8'hF0 ? 3 : lead >= 8'hE0 ? 2 : 1;
      n = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) put_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      put_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      put_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps in between.
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        in_fire;
  text_word_t  next_word;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      in_fire = s_axis_tvalid_i && s_axis_tready_o;
      if (in_fire) begin
        lex_word(s_axis_tdata_i, s_axis_tlast_i);
        words_taken++;
      end
      if (!s_axis_tvalid_i || in_fire) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (text_words.size() == 0 ||
                     (text_words[0].pause && tokens_due.size() != 0)) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          next_word = text_words.pop_front();
          s_axis_tdata_i <= next_word.b;
          s_axis_tlast_i <= next_word.eot;
          s_axis_tvalid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) :
                       $urandom_range(0, 2);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern that changes with a running cycle counter, plus one long hold-off.
  // ---------------------------------------------------------------------------

  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!long_hold_done && n_tokens >= 120) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_cycle[7:6])
          2'd0: m_axis_tready_i <= 1'b1;
          2'd1: m_axis_tready_i <= $urandom_range(0, 1) == 1;
          2'd2: m_axis_tready_i <= $urandom_range(0, 3) == 0;
          default: m_axis_tready_i <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted token against the oldest one due.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  token_t want_tok;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_tokens++;
      if (tokens_due.size() == 0) begin
        $error("token of kind %0d at offset %0d with none due", m_axis_tuser_o,
               m_axis_tdata_o[31:0]);
        n_fail++;
      end else begin
        want_tok = tokens_due.pop_front();
        check_field("token_kind", 64'(want_tok.kind), 64'(m_axis_tuser_o));
        check_field("start_pos", 64'(want_tok.start_pos), 64'(m_axis_tdata_o[31:0]));
        check_field("byte_length", 64'(want_tok.byte_length), 64'(m_axis_tdata_o[63:32]));
        check_field("number_value", 64'(want_tok.number_value), 64'(m_axis_tdata_o[126:64]));
        check_field("error_code", 64'(want_tok.error_code), 64'(m_axis_tdata_o[128:127]));
        check_field("last", 64'(want_tok.last), 64'(m_axis_tlast_o));
        if (want_tok.error_code == ERR_LARGE) n_large++;
        if (want_tok.error_code == ERR_UTF8) n_utf8++;
        if (want_tok.kind == TK_EOF) n_eof++;
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d tokens still due",
               STALL_LIMIT, tokens_due.size());
      $display("utf8_expression_lexer_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    // Directed text: small numbers, a space, every operator, multibyte spaces,
    // tab, a stray continuation byte, an out-of-range lead byte, an overlong and a surrogate form,
    // a cut-off sequence at end of text, NUL and a four-byte character.
    put_string("12 +-*/()");
    put_char(21'hA0);
    put_string("90");
    put_char(21'h2028);
    put_word(8'h09, 1'b0);
    put_word(8'h80, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'hE0, 1'b0);
    put_word(8'h80, 1'b0);
    put_word(8'hED, 1'b0);
    put_word(8'hA0, 1'b0);
    put_word(8'hF4, 1'b0);
    put_word(8'h00, 1'b1);
    put_word(8'h00, 1'b0);
    put_char(21'h1F600);

    // Random part, opened by the largest number that fits and the first that does not.
    pause_next = 1'b1;
    put_string("9223372036854775807 9223372036854775808 ");
    while (text_words.size() < 30 + RANDOM_WORDS) begin
      if (text_words.size() > 30 + RANDOM_WORDS / 2 && text_words.size() < 36 + RANDOM_WORDS / 2)
        pause_next = 1'b1;
      put_random_text();
    end
    put_word(8'hFF, 1'b1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_words.size() != 0 || s_axis_tvalid_i || tokens_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Lexed %0d bytes and end marks into %0d tokens, among them %0d end-of-file,",
             words_taken, n_tokens, n_eof);
    $display("%0d invalid UTF-8 and %0d oversized numbers, under bursty input and stalls.",
             n_utf8, n_large);
    if (n_fail == 0) begin
      $display("utf8_expression_lexer_core regression: pass");
    end else begin
      $display("utf8_expression_lexer_core regression: fail");
    end
    $finish;
  end

endmodule
